>>> rtl/core/soa_pkg.sv
// ----------------------------------------------------------------------------
// soa_pkg
// Shared types and constants of the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

	localparam int MAX_SLABS     = 16;
	localparam int MAX_SLOTS     = 512;
	localparam int PAGE_SHIFT    = 12;
	localparam int HEADER_BYTES  = 64;
	localparam int MAX_PAGES     = 16;
	localparam int WASTE_PERCENT = 10;
	localparam int MAX_SIZE      = 4096;
	localparam int MIN_SIZE      = 8;

	localparam int ADDR_W  = 20;
	localparam int SIZE_W  = 13;
	localparam int SLOT_W  = 10;
	localparam int SLAB_W  = 4;
	localparam int TOTAL_W = 5;
	localparam int PAGE_W  = 5;
	localparam int SPAN_W  = 17;

	localparam int RESET_SLOTS = 504;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_FREED     = 2'd1,
		ST_NO_SPACE  = 2'd2,
		ST_BAD_FREE  = 2'd3
	} status_t;

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	localparam logic [2:0] REG_OBJ_SIZE = 3'd0;

	typedef struct packed {
		logic                mode;
		logic [ADDR_W-1:0]   free_address;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [ADDR_W-1:0]   address;
		logic [TOTAL_W-1:0]  slabs_in_use;
	} res_word_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   head;
		logic [SLOT_W-1:0]   live;
	} slab_info_t;

endpackage

>>> rtl/core/slab_object_allocator_core.sv
// ----------------------------------------------------------------------------
// slab_object_allocator_core
// Fixed-size object allocator over up to sixteen slabs with per-slab free lists.
// ----------------------------------------------------------------------------
// channel   direction  handshake              word
// cmd       in         cmd_valid / cmd_ready  mode, free_address
// res       out        res_valid / res_ready  status, address, slabs_in_use
// apb       in/out     psel/penable/pready    object size at byte address 0
//
// Alloc, existing slab: S_SRD, S_SCHK per slab scanned, then S_PRD, S_PWR.
// Allocate that creates a slab: one cycle per slot to chain the free list.
// Free: restoring division (slab), S_FCHK1, division (slot), S_FCHK2, S_FRD.
// A size write recomputes geometry with up to 16 divisions.
// No clearing pass after reset; one item is in work at a time, cmd_ready is
// high only in idle, and a waiting result does not block the next command.
// ----------------------------------------------------------------------------
module slab_object_allocator_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  soa_pkg::cmd_word_t    cmd,
	output logic                  res_valid,
	input  logic                  res_ready,
	output soa_pkg::res_word_t    res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_GEO   = 14'b00000000000010,
		S_GCHK  = 14'b00000000000100,
		S_DIV   = 14'b00000000001000,
		S_SRD   = 14'b00000000010000,
		S_SCHK  = 14'b00000000100000,
		S_INIT  = 14'b00000001000000,
		S_PRD   = 14'b00000010000000,
		S_PWR   = 14'b00000100000000,
		S_FCHK1 = 14'b00001000000000,
		S_FCHK2 = 14'b00010000000000,
		S_FRD   = 14'b00100000000000,
		S_DONE  = 14'b01000000000000,
		S_SPARE = 14'b10000000000000
	} state_t;

	state_t                              state_q, ret_q;
	logic [soa_pkg::SIZE_W-1:0]          req_q, sz_q;
	logic [soa_pkg::PAGE_W-1:0]          pages_q, page_q;
	logic [soa_pkg::SLOT_W-1:0]          slots_q;
	logic [soa_pkg::TOTAL_W-1:0]         total_q;
	logic [soa_pkg::SLAB_W-1:0]          idx_q, slab_q;
	logic [soa_pkg::SLOT_W-1:0]          k_q, head_q, live_q;
	logic [soa_pkg::SPAN_W-1:0]          div_rem_q, div_den_q;
	logic [soa_pkg::ADDR_W-1:0]          div_quo_q;
	logic [4:0]                          div_cnt_q;
	logic [22:0]                         mul_q;
	logic [8:0]                          base_q;
	logic [1:0]                          res_status_q;
	logic [soa_pkg::ADDR_W-1:0]          res_addr_q;
	logic                                res_valid_q;
	soa_pkg::res_word_t                  res_q;

	soa_pkg::slab_info_t                 slab_mem [soa_pkg::MAX_SLABS];
	logic [soa_pkg::SLOT_W-1:0]          next_mem [soa_pkg::MAX_SLABS * soa_pkg::MAX_SLOTS];
	soa_pkg::slab_info_t                 sm_rd_q, sm_wdata;
	logic [soa_pkg::SLOT_W-1:0]          nm_rd_q, nm_wdata;
	logic [soa_pkg::SLAB_W-1:0]          sm_raddr;
	logic                                sm_we, nm_we;
	logic [12:0]                         nm_raddr, nm_waddr;

	logic                                cfg_wr;
	logic [soa_pkg::SIZE_W-1:0]          req_w, req_clip, sz_new;
	logic [17:0]                         div_trial;
	logic                                div_ge;
	logic [17:0]                         div_diff;
	logic                                can_create, slab_found, last_slab, out_free;
	logic [27:0]                         waste_lhs, waste_rhs;
	logic [23:0]                         addr_sum;

	assign pready    = 1'b1;
	assign prdata    = {19'd0, req_q};
	assign cfg_wr    = psel && penable && pwrite && (paddr == soa_pkg::REG_OBJ_SIZE);
	assign cmd_ready = (state_q == S_IDLE) && !cfg_wr;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign req_w    = pwdata[soa_pkg::SIZE_W-1:0];
	assign req_clip = (req_w > 13'(soa_pkg::MAX_SIZE)) ? 13'(soa_pkg::MAX_SIZE) : req_w;
	assign sz_new   = (req_clip <= 13'(soa_pkg::MIN_SIZE)) ? 13'(soa_pkg::MIN_SIZE)
	                : ((req_clip + 13'd15) & ~13'd15);

	assign div_trial = {div_rem_q, div_quo_q[soa_pkg::ADDR_W-1]};
	assign div_ge    = div_trial >= {1'b0, div_den_q};
	assign div_diff  = div_trial - {1'b0, div_den_q};

	assign can_create = (total_q < 5'(soa_pkg::MAX_SLABS)) && (slots_q != '0);
	assign slab_found = (sm_rd_q.live < slots_q) && (sm_rd_q.head < 10'(soa_pkg::MAX_SLOTS));
	assign last_slab  = ({1'b0, idx_q} + 5'd1) == total_q;
	assign out_free   = !res_valid_q || res_ready;

	assign waste_lhs = 28'(div_rem_q) * 28'd100;
	assign waste_rhs = 28'({page_q, 12'd0}) * 28'(soa_pkg::WASTE_PERCENT);
	assign addr_sum  = 24'({base_q, 12'd0}) + 24'(mul_q);

	always_comb begin
		sm_raddr = idx_q;
		sm_we    = 1'b0;
		sm_wdata = '0;
		nm_raddr = {slab_q, head_q[8:0]};
		nm_we    = 1'b0;
		nm_waddr = {slab_q, k_q[8:0]};
		nm_wdata = k_q + 10'd1;
		case (state_q)
			S_INIT: begin
				nm_we = 1'b1;
			end
			S_PWR: begin
				sm_we         = 1'b1;
				sm_wdata.head = nm_rd_q;
				sm_wdata.live = live_q + 10'd1;
			end
			S_FCHK2: begin
				sm_raddr = slab_q;
			end
			S_FRD: begin
				if (sm_rd_q.live != '0) begin
					nm_we         = 1'b1;
					nm_wdata      = sm_rd_q.head;
					sm_we         = 1'b1;
					sm_wdata.head = k_q;
					sm_wdata.live = sm_rd_q.live - 10'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		sm_rd_q <= slab_mem[sm_raddr];
		if (sm_we) begin
			slab_mem[slab_q] <= sm_wdata;
		end
	end

	always_ff @(posedge clk) begin
		nm_rd_q <= next_mem[nm_raddr];
		if (nm_we) begin
			next_mem[nm_waddr] <= nm_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			req_q        <= 13'(soa_pkg::MIN_SIZE);
			sz_q         <= 13'(soa_pkg::MIN_SIZE);
			pages_q      <= 5'd1;
			page_q       <= 5'd1;
			slots_q      <= 10'(soa_pkg::RESET_SLOTS);
			total_q      <= '0;
			idx_q        <= '0;
			slab_q       <= '0;
			k_q          <= '0;
			head_q       <= '0;
			live_q       <= '0;
			div_rem_q    <= '0;
			div_den_q    <= '0;
			div_quo_q    <= '0;
			div_cnt_q    <= '0;
			mul_q        <= '0;
			base_q       <= '0;
			res_status_q <= '0;
			res_addr_q   <= '0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			if (res_valid_q && res_ready && (cfg_wr || (state_q != S_DONE))) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				req_q   <= req_w;
				sz_q    <= sz_new;
				page_q  <= 5'd1;
				state_q <= S_GEO;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (cmd_valid) begin
							if (cmd.mode == soa_pkg::MODE_FREE) begin
								div_quo_q <= cmd.free_address;
								div_rem_q <= '0;
								div_den_q <= {pages_q, 12'd0};
								div_cnt_q <= '0;
								ret_q     <= S_FCHK1;
								state_q   <= S_DIV;
							end else if (total_q != '0) begin
								idx_q   <= '0;
								state_q <= S_SRD;
							end else if (can_create) begin
								slab_q  <= total_q[soa_pkg::SLAB_W-1:0];
								k_q     <= '0;
								state_q <= S_INIT;
							end else begin
								res_status_q <= soa_pkg::ST_NO_SPACE;
								res_addr_q   <= '0;
								state_q      <= S_DONE;
							end
						end
					end
					S_GEO: begin
						div_quo_q <= 20'({page_q, 12'd0} - 17'(soa_pkg::HEADER_BYTES));
						div_rem_q <= '0;
						div_den_q <= 17'(sz_q);
						div_cnt_q <= '0;
						ret_q     <= S_GCHK;
						state_q   <= S_DIV;
					end
					S_GCHK: begin
						if ((waste_lhs < waste_rhs) || (page_q == 5'(soa_pkg::MAX_PAGES))) begin
							pages_q <= page_q;
							slots_q <= (div_quo_q > 20'(soa_pkg::MAX_SLOTS))
							         ? 10'(soa_pkg::MAX_SLOTS) : div_quo_q[9:0];
							total_q <= '0;
							state_q <= S_IDLE;
						end else begin
							page_q  <= page_q + 5'd1;
							state_q <= S_GEO;
						end
					end
					S_DIV: begin
						div_rem_q <= div_ge ? div_diff[16:0] : div_trial[16:0];
						div_quo_q <= {div_quo_q[18:0], div_ge};
						div_cnt_q <= div_cnt_q + 5'd1;
						if (div_cnt_q == 5'(soa_pkg::ADDR_W - 1)) begin
							state_q <= ret_q;
						end
					end
					S_SRD: begin
						state_q <= S_SCHK;
					end
					S_SCHK: begin
						if (slab_found) begin
							slab_q  <= idx_q;
							head_q  <= sm_rd_q.head;
							live_q  <= sm_rd_q.live;
							state_q <= S_PRD;
						end else if (!last_slab) begin
							idx_q   <= idx_q + 4'd1;
							state_q <= S_SRD;
						end else if (can_create) begin
							slab_q  <= total_q[soa_pkg::SLAB_W-1:0];
							k_q     <= '0;
							state_q <= S_INIT;
						end else begin
							res_status_q <= soa_pkg::ST_NO_SPACE;
							res_addr_q   <= '0;
							state_q      <= S_DONE;
						end
					end
					S_INIT: begin
						k_q <= k_q + 10'd1;
						if (k_q == slots_q - 10'd1) begin
							head_q  <= '0;
							live_q  <= '0;
							total_q <= total_q + 5'd1;
							state_q <= S_PRD;
						end
					end
					S_PRD: begin
						mul_q   <= 23'(head_q) * 23'(sz_q);
						base_q  <= 9'(slab_q) * 9'(pages_q);
						state_q <= S_PWR;
					end
					S_PWR: begin
						res_status_q <= soa_pkg::ST_ALLOCATED;
						res_addr_q   <= addr_sum[soa_pkg::ADDR_W-1:0];
						state_q      <= S_DONE;
					end
					S_FCHK1: begin
						if (div_quo_q >= 20'(total_q)) begin
							res_status_q <= soa_pkg::ST_BAD_FREE;
							res_addr_q   <= '0;
							state_q      <= S_DONE;
						end else begin
							slab_q    <= div_quo_q[soa_pkg::SLAB_W-1:0];
							div_quo_q <= 20'(div_rem_q);
							div_rem_q <= '0;
							div_den_q <= 17'(sz_q);
							div_cnt_q <= '0;
							ret_q     <= S_FCHK2;
							state_q   <= S_DIV;
						end
					end
					S_FCHK2: begin
						if ((div_quo_q >= 20'(slots_q)) || (div_rem_q != '0)) begin
							res_status_q <= soa_pkg::ST_BAD_FREE;
							res_addr_q   <= '0;
							state_q      <= S_DONE;
						end else begin
							k_q     <= div_quo_q[soa_pkg::SLOT_W-1:0];
							state_q <= S_FRD;
						end
					end
					S_FRD: begin
						res_status_q <= (sm_rd_q.live == '0) ? soa_pkg::ST_BAD_FREE
						              : soa_pkg::ST_FREED;
						res_addr_q   <= '0;
						state_q      <= S_DONE;
					end
					S_DONE: begin
						if (out_free) begin
							res_q.status       <= res_status_q;
							res_q.address      <= res_addr_q;
							res_q.slabs_in_use <= total_q;
							res_valid_q        <= 1'b1;
							state_q            <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

endmodule

>>> rtl/core/soa_checker.sv
// ----------------------------------------------------------------------------
// soa_checker
// Port-level checks of the slab object allocator, bound to the top level.
// ----------------------------------------------------------------------------
module soa_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  logic                  cmd_ready,
	input  logic                  res_valid,
	input  logic                  res_ready,
	input  soa_pkg::res_word_t    res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status != soa_pkg::ST_ALLOCATED) |-> res.address == '0)
		else $error("nonzero address on non-allocate result");

	a_slab_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.slabs_in_use <= 5'(soa_pkg::MAX_SLABS))
		else $error("slab count beyond limit");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second command taken while one is in work");

endmodule

bind slab_object_allocator_core soa_checker u_soa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks slab_object_allocator_core against a cycle-free model of the slab
// free lists: directed allocate/free cases, size extremes with a full cache,
// a long result stall, then random traffic over several object sizes.
// ----------------------------------------------------------------------------
module testbench;

	logic                clk;
	logic                arst_n;
	logic                cmd_valid;
	logic                cmd_ready;
	soa_pkg::cmd_word_t  cmd;
	logic                res_valid;
	logic                res_ready;
	soa_pkg::res_word_t  res;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	slab_object_allocator_core uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// allocator model state
	int unsigned obj_bytes, slab_slots, slab_pages, slab_count;
	int unsigned list_head [soa_pkg::MAX_SLABS];
	int unsigned live_count [soa_pkg::MAX_SLABS];
	int unsigned slot_link [soa_pkg::MAX_SLABS*soa_pkg::MAX_SLOTS];

	soa_pkg::res_word_t pending_words[$];
	int unsigned owned_addrs[$];
	int          errors = 0;
	bit          idle_on = 0;
	int          rx_wait = 0;
	int          rx_hold = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#50_000_000;
		$display("FAIL slab_object_allocator_core");
		$finish;
	end

	function automatic void load_geometry(int unsigned req);
		int unsigned sz, p, region;
		if (req > soa_pkg::MAX_SIZE) req = soa_pkg::MAX_SIZE;
		sz = (req <= soa_pkg::MIN_SIZE) ? soa_pkg::MIN_SIZE : ((req + 15) & ~32'd15);
		slab_pages = soa_pkg::MAX_PAGES;
		for (p = 1; p <= soa_pkg::MAX_PAGES; p++) begin
			region = p << soa_pkg::PAGE_SHIFT;
			if (((region - soa_pkg::HEADER_BYTES) % sz) * 100 / region
					< soa_pkg::WASTE_PERCENT) begin
				slab_pages = p;
				break;
			end
		end
		slab_slots = ((slab_pages << soa_pkg::PAGE_SHIFT) - soa_pkg::HEADER_BYTES) / sz;
		if (slab_slots > soa_pkg::MAX_SLOTS) slab_slots = soa_pkg::MAX_SLOTS;
		obj_bytes = sz;
		slab_count = 0;
	endfunction

	function automatic soa_pkg::res_word_t predict_word(soa_pkg::cmd_word_t w);
		int unsigned span, s, k, h, a, off;
		int found;
		soa_pkg::res_word_t r;
		span = slab_pages << soa_pkg::PAGE_SHIFT;
		r = '0;
		if (w.mode == soa_pkg::MODE_ALLOC) begin
			found = -1;
			for (s = 0; s < slab_count; s++) begin
				if (live_count[s] < slab_slots && list_head[s] < soa_pkg::MAX_SLOTS) begin
					found = s;
					break;
				end
			end
			if (found < 0 && slab_count < soa_pkg::MAX_SLABS && slab_slots > 0) begin
				s = slab_count;
				for (k = 0; k < slab_slots; k++)
					slot_link[s*soa_pkg::MAX_SLOTS + k] = k + 1;
				list_head[s] = 0;
				live_count[s] = 0;
				slab_count++;
				found = s;
			end
			if (found < 0) begin
				r.status = soa_pkg::ST_NO_SPACE;
			end else begin
				s = found;
				h = list_head[s];
				a = (s * span + h * obj_bytes) & 32'hFFFFF;
				r.address = a[soa_pkg::ADDR_W-1:0];
				list_head[s] = slot_link[s*soa_pkg::MAX_SLOTS + h];
				live_count[s]++;
				r.status = soa_pkg::ST_ALLOCATED;
				owned_addrs.push_back(a);
			end
		end else begin
			a = w.free_address;
			s = a / span;
			off = a % span;
			if (s >= slab_count || off >= slab_slots * obj_bytes ||
					off % obj_bytes != 0 || live_count[s] == 0) begin
				r.status = soa_pkg::ST_BAD_FREE;
			end else begin
				k = off / obj_bytes;
				slot_link[s*soa_pkg::MAX_SLOTS + k] = list_head[s];
				list_head[s] = k;
				live_count[s]--;
				r.status = soa_pkg::ST_FREED;
			end
		end
		r.slabs_in_use = slab_count[soa_pkg::TOTAL_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// result side: check each word, then draw the stall before the next one
	always @(posedge clk) begin : rx_side
		soa_pkg::res_word_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word", res.status, -1);
			end else begin
				want = pending_words.pop_front();
				if (res.status !== want.status)
					report_mismatch("status", res.status, want.status);
				if (res.address !== want.address)
					report_mismatch("address", res.address, want.address);
				if (res.slabs_in_use !== want.slabs_in_use)
					report_mismatch("slabs_in_use", res.slabs_in_use, want.slabs_in_use);
			end
			rx_wait = idle_on ? $urandom_range(0, 11) : 0;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			res_ready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= arst_n;
		end
	end

	task automatic send_word(soa_pkg::mode_t m, int unsigned addr);
		soa_pkg::cmd_word_t w;
		int gap;
		w.mode = m;
		w.free_address = addr[soa_pkg::ADDR_W-1:0];
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (!cmd_ready);
		pending_words.push_back(predict_word(w));
	endtask

	task automatic drain_all();
		cmd_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_size(int unsigned v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= soa_pkg::REG_OBJ_SIZE;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		load_geometry(v & 32'h1FFF);
		owned_addrs.delete();
	endtask

	task automatic test_default_size();
		idle_on = 1;
		send_word(soa_pkg::MODE_ALLOC, 0);
		send_word(soa_pkg::MODE_ALLOC, 20'hFFFFF);
		send_word(soa_pkg::MODE_ALLOC, 0);
		send_word(soa_pkg::MODE_FREE, 8);
		send_word(soa_pkg::MODE_ALLOC, 0);
		send_word(soa_pkg::MODE_FREE, 4);
		send_word(soa_pkg::MODE_FREE, 4032);
		send_word(soa_pkg::MODE_FREE, 4096);
		send_word(soa_pkg::MODE_FREE, 20'hFFFFF);
		send_word(soa_pkg::MODE_FREE, 0);
		send_word(soa_pkg::MODE_FREE, 0);
		send_word(soa_pkg::MODE_FREE, 16);
		send_word(soa_pkg::MODE_FREE, 8);
		send_word(soa_pkg::MODE_ALLOC, 0);
		drain_all();
	endtask

	task automatic test_size_extremes();
		write_size(0);
		send_word(soa_pkg::MODE_ALLOC, 0);
		send_word(soa_pkg::MODE_FREE, 0);
		drain_all();
		write_size(13'h1FFF);
		idle_on = 0;
		repeat (soa_pkg::MAX_SLABS * 9 + 2) send_word(soa_pkg::MODE_ALLOC, 0);
		send_word(soa_pkg::MODE_FREE, 36864);
		send_word(soa_pkg::MODE_FREE, 15 * 40960 + 4096);
		send_word(soa_pkg::MODE_ALLOC, 0);
		drain_all();
		write_size(soa_pkg::MAX_SIZE);
		send_word(soa_pkg::MODE_ALLOC, 0);
		drain_all();
	endtask

	task automatic test_result_stall();
		write_size(24);
		idle_on = 0;
		@(posedge clk);
		rx_hold = 400;
		repeat (24) send_word(soa_pkg::MODE_ALLOC, 0);
		drain_all();
	endtask

	task automatic test_random_traffic();
		int unsigned sizes[8] = '{1, 9, 17, 100, 4096, 8, 0, 0};
		int unsigned pick, ph, n;
		sizes[6] = $urandom_range(1, 4096);
		sizes[7] = $urandom_range(0, 8191);
		for (ph = 0; ph < 8; ph++) begin
			write_size(sizes[ph]);
			idle_on = ph[0];
			for (n = 0; n < 60; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45 || (pick < 80 && owned_addrs.size() == 0)) begin
					send_word(soa_pkg::MODE_ALLOC, $urandom);
				end else if (pick < 80) begin
					pick = $urandom_range(0, owned_addrs.size() - 1);
					send_word(soa_pkg::MODE_FREE, owned_addrs[pick]);
					owned_addrs.delete(pick);
				end else begin
					send_word(soa_pkg::MODE_FREE, $urandom);
				end
			end
			drain_all();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		load_geometry(soa_pkg::MIN_SIZE);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_size();
		test_size_extremes();
		test_result_stall();
		test_random_traffic();
		if (errors == 0)
			$display("PASS slab_object_allocator_core");
		else
			$display("FAIL slab_object_allocator_core");
		$finish;
	end

endmodule

>>> slab_object_allocator_core.f
rtl/core/soa_pkg.sv
rtl/core/slab_object_allocator_core.sv
rtl/core/soa_checker.sv
tb/testbench.sv
